FILE: rtl/core/srv_pkg.sv
// Shared types, codes and constants of the stereo convolution reverb.
// Used by the MAC datapath, the top level and the testbench.
package srv_pkg;

    localparam int MAX_TAPS_DEF = 1024;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IR_LENGTH    = 1'b1;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] MODE_MONO  = 2'd0;
    localparam logic [1:0] MODE_QUASI = 2'd1;
    localparam logic [1:0] MODE_TRUE  = 2'd2;

    typedef struct packed {
        logic [1:0]          command;
        logic [9:0]          tap_index;
        logic signed [15:0]  coef_left;
        logic signed [15:0]  coef_right;
        logic signed [15:0]  sample_left;
        logic signed [15:0]  sample_right;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0]  out_left;
        logic signed [23:0]  out_right;
        logic [23:0]         peak_left;
        logic [23:0]         peak_right;
    } t_out_item;

    // Control from the sequencer to the MAC, aligned with the memory read data.
    typedef struct packed {
        logic        clr;
        logic        valid;
        logic        mask;
        logic [1:0]  mode;
    } t_mac_ctl;

endpackage

FILE: rtl/core/srv_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// The payload type is a parameter, normally a struct from srv_pkg.
interface srv_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/srv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module srv_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/srv_mac.sv
// Two-channel multiply-accumulate datapath with the final shift and saturation.
// Uses srv_pkg for the control struct and mode codes.
module srv_mac #(
    parameter int ACC_W = 45
) (
    input  logic              i_clk,
    input  srv_pkg::t_mac_ctl i_ctl,
    input  logic [31:0]       i_hist,
    input  logic [31:0]       i_taps,
    output logic              o_busy,
    output logic [23:0]       o_yl,
    output logic [23:0]       o_yr
);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(srv_pkg::OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(srv_pkg::OUT_MIN);

    logic signed [15:0]      xl, xr, hl, hr;
    logic signed [16:0]      h;
    logic signed [32:0]      pl, pr;
    logic signed [32:0]      r_pl, r_pr;
    logic                    r_pv;
    logic signed [ACC_W-1:0] r_acc_l, r_acc_r;
    logic signed [ACC_W-1:0] sl, sr;
    logic                    is_true, is_mono;

    assign is_true = (i_ctl.mode == srv_pkg::MODE_TRUE);
    assign is_mono = !((i_ctl.mode == srv_pkg::MODE_QUASI) || is_true);

    always_comb begin
        // History entries older than the samples taken since the last clear read as zero.
        xl = i_ctl.mask ? $signed(i_hist[15:0])  : 16'sd0;
        xr = i_ctl.mask ? $signed(i_hist[31:16]) : 16'sd0;
        hl = $signed(i_taps[15:0]);
        hr = $signed(i_taps[31:16]);
        h  = is_true ? (17'(hl) + 17'(hr)) : 17'(hl);
        pl = 33'(xl) * 33'(h);
        pr = 33'(xr) * 33'(h);
    end

    always_ff @(posedge i_clk) begin
        r_pl <= pl;
        r_pr <= pr;
        r_pv <= i_ctl.valid;
        if (i_ctl.clr) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_pv) begin
            r_acc_l <= r_acc_l + ACC_W'(r_pl);
            r_acc_r <= r_acc_r + ACC_W'(r_pr);
        end
    end

    // True stereo folds the halving into the shift.
    always_comb begin
        sl = is_true ? (r_acc_l >>> 16) : (r_acc_l >>> 15);
        sr = is_true ? (r_acc_r >>> 16) : (r_acc_r >>> 15);
        if (sl > SAT_HI) begin
            o_yl = SAT_HI[23:0];
        end else if (sl < SAT_LO) begin
            o_yl = SAT_LO[23:0];
        end else begin
            o_yl = sl[23:0];
        end
        if (is_mono) begin
            o_yr = '0;
        end else if (sr > SAT_HI) begin
            o_yr = SAT_HI[23:0];
        end else if (sr < SAT_LO) begin
            o_yr = SAT_LO[23:0];
        end else begin
            o_yr = sr[23:0];
        end
    end

    assign o_busy = r_pv | i_ctl.valid | i_ctl.clr;
endmodule

FILE: rtl/core/stereo_convolution_reverb.sv
// Stereo convolution reverb: direct FIR over a history memory and a tap memory.
// Load and clear complete while idle; a sample passes the run, drain and output states over
// ir_length taps, ir_length capped at MAX_TAPS (the run state is skipped when it is zero).
// Input is ready only when idle, so a new item waits until the result enters the output register.
// Reset (synchronous, active low) empties the history by a fill count, with no clearing pass.
// Tap memory contents are undefined after reset until loaded.
// Depends on srv_pkg, srv_stream_if, srv_ram and srv_mac.
module stereo_convolution_reverb #(
    parameter int MAX_TAPS = srv_pkg::MAX_TAPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [srv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    srv_stream_if.sink                    i_in,
    srv_stream_if.source                  o_out
);
    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = 34 + LW;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state             r_state;
    logic [1:0]         r_mode;
    logic [10:0]        r_ir_len;
    logic [AW-1:0]      r_ptr, r_rd_idx;
    logic [LW-1:0]      r_fill, r_k, r_len, len;
    logic               r_clr, r_p1_valid, r_p1_mask;
    logic [23:0]        r_yl, r_yr, r_peak_l, r_peak_r;
    logic               r_o_valid;
    srv_pkg::t_out_item r_o_data;

    srv_pkg::t_in_item  in_item;
    srv_pkg::t_mac_ctl  mac_ctl;
    logic               in_xfer, out_free, mac_busy;
    logic [23:0]        mac_yl, mac_yr, mag_l, mag_r, n_peak_l, n_peak_r;
    logic               hist_we, tap_we, tap_in_range;
    logic [AW+9:0]      tap_wide;
    logic [31:0]        hist_q, tap_q;

    assign in_item  = i_in.data;
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_o_valid || o_out.ready;

    assign tap_wide     = (AW + 10)'(in_item.tap_index);
    assign tap_in_range = (32'(in_item.tap_index) < 32'(MAX_TAPS));
    assign tap_we  = in_xfer && (in_item.command == srv_pkg::CMD_LOAD) && tap_in_range;
    assign hist_we = in_xfer && (in_item.command == srv_pkg::CMD_SAMPLE);

    always_comb begin
        if (32'(r_ir_len) > 32'(MAX_TAPS)) begin
            len = LW'(MAX_TAPS);
        end else begin
            len = LW'(r_ir_len);
        end
    end

    srv_ram #(.W(32), .DEPTH(MAX_TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_ptr),
        .i_wdata ({in_item.sample_right, in_item.sample_left}),
        .i_raddr (r_rd_idx),
        .o_rdata (hist_q)
    );

    srv_ram #(.W(32), .DEPTH(MAX_TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_wide[AW-1:0]),
        .i_wdata ({in_item.coef_right, in_item.coef_left}),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (tap_q)
    );

    assign mac_ctl = '{clr: r_clr, valid: r_p1_valid, mask: r_p1_mask, mode: r_mode};

    srv_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_hist (hist_q),
        .i_taps (tap_q),
        .o_busy (mac_busy),
        .o_yl   (mac_yl),
        .o_yr   (mac_yr)
    );

    // Magnitude of a 24-bit result fits 24 unsigned bits, the most negative value too.
    always_comb begin
        mag_l    = r_yl[23] ? 24'(-{r_yl[23], r_yl}) : r_yl;
        mag_r    = r_yr[23] ? 24'(-{r_yr[23], r_yr}) : r_yr;
        n_peak_l = (mag_l > r_peak_l) ? mag_l : r_peak_l;
        n_peak_r = (mag_r > r_peak_r) ? mag_r : r_peak_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= srv_pkg::MODE_MONO;
            r_ir_len <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srv_pkg::REG_CHANNEL_MODE: r_mode   <= i_cfg_data[1:0];
                srv_pkg::REG_IR_LENGTH:    r_ir_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ptr      <= '0;
            r_fill     <= '0;
            r_peak_l   <= '0;
            r_peak_r   <= '0;
            r_clr      <= 1'b0;
            r_p1_valid <= 1'b0;
            r_p1_mask  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_k        <= '0;
            r_len      <= '0;
            r_rd_idx   <= '0;
        end else begin
            // The accumulator is cleared on the cycle after a sample transfer.
            r_clr      <= hist_we;
            r_p1_valid <= (r_state == ST_RUN);
            r_o_valid  <= (r_state == ST_OUT && out_free) || (r_o_valid && !o_out.ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        case (in_item.command)
                            srv_pkg::CMD_CLEAR: begin
                                r_ptr    <= '0;
                                r_fill   <= '0;
                                r_peak_l <= '0;
                                r_peak_r <= '0;
                            end
                            srv_pkg::CMD_SAMPLE: begin
                                r_rd_idx <= r_ptr;
                                r_ptr    <= (r_ptr == AW'(MAX_TAPS - 1)) ? '0 : r_ptr + 1'b1;
                                r_fill   <= (r_fill == LW'(MAX_TAPS)) ? r_fill : r_fill + 1'b1;
                                r_k      <= '0;
                                r_len    <= len;
                                r_state  <= (len == '0) ? ST_DRAIN : ST_RUN;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN: begin
                    r_p1_mask  <= (r_k < r_fill);
                    r_k        <= r_k + 1'b1;
                    r_rd_idx   <= (r_rd_idx == '0) ? AW'(MAX_TAPS - 1) : r_rd_idx - 1'b1;
                    if ((LW + 1)'(r_k) + 1'b1 == (LW + 1)'(r_len)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!mac_busy) begin
                        r_yl    <= mac_yl;
                        r_yr    <= mac_yr;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_peak_l  <= n_peak_l;
                        r_peak_r  <= n_peak_r;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_data.out_left   <= r_yl;
            r_o_data.out_right  <= r_yr;
            r_o_data.peak_left  <= n_peak_l;
            r_o_data.peak_right <= n_peak_r;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(MAX_TAPS))
        else $error("history fill count above depth");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_k < r_len))
        else $error("tap counter ran past the tap length");

    a_sample_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && in_item.command == srv_pkg::CMD_SAMPLE) |=> (r_state != ST_IDLE))
        else $error("sample transfer did not start a convolution pass");

    a_out_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !out_free) |=> (r_state == ST_OUT))
        else $error("result left the sequencer while the output register was full");

    a_peak_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=>
            (r_peak_l >= $past(r_peak_l) && r_peak_r >= $past(r_peak_r)))
        else $error("peak decreased on a result");
endmodule

FILE: tb/tb_stereo_convolution_reverb.sv
// Self-checking testbench for the stereo convolution reverb: directed and random streams,
// a per-transfer predictor of the FIR, the saturation and the peak tracking.
// Depends on srv_pkg, srv_stream_if and the stereo_convolution_reverb top level.
`timescale 1ns / 1ps

module tb_stereo_convolution_reverb;

    localparam int NTAPS        = srv_pkg::MAX_TAPS_DEF;
    localparam int RANDOM_ITEMS = 45;
    localparam int SAT_TAPS     = 260;
    localparam int SAT_SAMPLES  = 258;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_CYC   = 16;
    localparam int TAIL_CYC     = 1100;
    localparam int MAX_REPORTS  = 100;

    // Codes the package leaves unnamed: a command the block ignores and a spare mode.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [srv_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [srv_pkg::CFG_DATA_W-1:0] cfg_data;

    srv_stream_if #(.T(srv_pkg::t_in_item))  in_if ();
    srv_stream_if #(.T(srv_pkg::t_out_item)) out_if ();

    stereo_convolution_reverb DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Predictor state: histories, taps, write pointer, peaks and register copies.
    logic signed [15:0] hist_l [NTAPS] = '{default: '0};
    logic signed [15:0] hist_r [NTAPS] = '{default: '0};
    logic signed [15:0] tap_l  [NTAPS] = '{default: '0};
    logic signed [15:0] tap_r  [NTAPS] = '{default: '0};
    int                 wr_ptr = 0;
    longint             peak_l = 0;
    longint             peak_r = 0;
    logic [1:0]         cur_mode = srv_pkg::MODE_MONO;
    int                 cur_len = NTAPS;

    srv_pkg::t_in_item  pending_items [$];
    srv_pkg::t_out_item expected_frames [$];
    srv_pkg::t_out_item want;

    int errors = 0;
    int frames_checked = 0;
    int items_taken = 0;
    int n_loads = 0;
    int n_clears = 0;
    int n_samples = 0;
    int settings_used = 0;
    int random_sent = 0;

    int          burst_left = 8;
    int          gap_left = 0;
    logic [31:0] rx_tick = '0;
    bit          hold_off_req = 1'b0;
    int          hold_off_left = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results still outstanding.", expected_frames.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint clip24(input longint v);
        if (v > srv_pkg::OUT_MAX) return srv_pkg::OUT_MAX;
        if (v < srv_pkg::OUT_MIN) return srv_pkg::OUT_MIN;
        return v;
    endfunction

    // Sum of history times taps, walking back from the newest sample.
    function automatic longint fir_sum(input bit right_ch, input bit both_taps, input int len);
        longint acc;
        longint h;
        longint s;
        int     idx;
        acc = 0;
        idx = wr_ptr;
        for (int k = 0; k < len; k++) begin
            h = tap_l[k];
            if (both_taps) h += tap_r[k];
            s = right_ch ? hist_r[idx] : hist_l[idx];
            acc += s * h;
            idx = (idx == 0) ? NTAPS - 1 : idx - 1;
        end
        return acc;
    endfunction

    task automatic reverb_step(input srv_pkg::t_in_item it);
        srv_pkg::t_out_item frame;
        longint             y_l;
        longint             y_r;
        int                 len;
        int                 shift;
        bit                 stereo_ir;
        case (it.command)
            srv_pkg::CMD_LOAD: begin
                tap_l[it.tap_index] = it.coef_left;
                tap_r[it.tap_index] = it.coef_right;
                n_loads++;
            end
            srv_pkg::CMD_CLEAR: begin
                hist_l = '{default: '0};
                hist_r = '{default: '0};
                wr_ptr = 0;
                peak_l = 0;
                peak_r = 0;
                n_clears++;
            end
            srv_pkg::CMD_SAMPLE: begin
                hist_l[wr_ptr] = it.sample_left;
                hist_r[wr_ptr] = it.sample_right;
                len = (cur_len > NTAPS) ? NTAPS : cur_len;
                stereo_ir = (cur_mode == srv_pkg::MODE_TRUE);
                // In true stereo the halving is folded into one extra bit of shift.
                shift = stereo_ir ? 16 : 15;
                y_l = clip24(fir_sum(1'b0, stereo_ir, len) >>> shift);
                if (cur_mode == srv_pkg::MODE_TRUE || cur_mode == srv_pkg::MODE_QUASI)
                    y_r = clip24(fir_sum(1'b1, stereo_ir, len) >>> shift);
                else
                    y_r = 0;
                wr_ptr = (wr_ptr + 1) % NTAPS;
                if ((y_l < 0 ? -y_l : y_l) > peak_l) peak_l = (y_l < 0) ? -y_l : y_l;
                if ((y_r < 0 ? -y_r : y_r) > peak_r) peak_r = (y_r < 0) ? -y_r : y_r;
                frame.out_left   = y_l[23:0];
                frame.out_right  = y_r[23:0];
                frame.peak_left  = peak_l[23:0];
                frame.peak_right = peak_r[23:0];
                expected_frames.push_back(frame);
                n_samples++;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%06h, actual 0x%06h",
                         $time, name, exp_v, act_v);
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                reverb_step(in_if.data);
                items_taken++;
            end
            if (in_if.valid && !in_if.ready) begin
                // Offer stays up until the transfer happens.
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_if.valid <= 1'b1;
                in_if.data  <= pending_items.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                           : $urandom_range(0, 3);
                end else begin
                    burst_left--;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each transfer and stalls on a rotating pattern.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_frames.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: unexpected result, expected none, actual %h",
                                 $time, out_if.data);
                end else begin
                    want = expected_frames.pop_front();
                    check_field("out_left", want.out_left, out_if.data.out_left);
                    check_field("out_right", want.out_right, out_if.data.out_right);
                    check_field("peak_left", want.peak_left, out_if.data.peak_left);
                    check_field("peak_right", want.peak_right, out_if.data.peak_right);
                    frames_checked++;
                end
            end
            rx_tick <= rx_tick + 1;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_off_left = LONG_HOLD;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (rx_tick[7:6])
                    2'd0: out_if.ready <= 1'b1;
                    2'd1: out_if.ready <= ($urandom_range(0, 1) == 1);
                    2'd2: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= (rx_tick[2:0] != 3'd0);
                endcase
            end
        end
    end

    task automatic queue_item(input logic [1:0] cmd, input int idx, input int cl, input int cr,
                              input int sl, input int sr);
        srv_pkg::t_in_item it;
        it.command      = cmd;
        it.tap_index    = idx[9:0];
        it.coef_left    = cl[15:0];
        it.coef_right   = cr[15:0];
        it.sample_left  = sl[15:0];
        it.sample_right = sr[15:0];
        pending_items.push_back(it);
    endtask

    function automatic int pick_sample();
        case ($urandom_range(0, 11))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_random(input int count);
        srv_pkg::t_in_item it;
        int                got;
        int                pick;
        got = 0;
        while (got < count) begin
            pick = $urandom_range(0, 99);
            it.command = (pick < 72) ? srv_pkg::CMD_SAMPLE :
                         (pick < 86) ? srv_pkg::CMD_LOAD :
                         (pick < 94) ? srv_pkg::CMD_CLEAR : CMD_UNUSED;
            it.tap_index    = 10'($urandom_range(0, NTAPS - 1));
            it.coef_left    = 16'(pick_sample());
            it.coef_right   = 16'(pick_sample());
            it.sample_left  = 16'(pick_sample());
            it.sample_right = 16'(pick_sample());
            pending_items.push_back(it);
            if (it.command != CMD_UNUSED) got++;
        end
        random_sent += got;
    endtask

    // Registers change only once the block has drained and load or clear work has settled.
    task automatic write_reg(input logic [srv_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[srv_pkg::CFG_DATA_W-1:0];
        if (idx == srv_pkg::REG_CHANNEL_MODE)
            cur_mode = value[1:0];
        else
            cur_len = value & 32'h7FF;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_if.valid || expected_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic set_phase(input logic [1:0] mode, input int len);
        wait_idle();
        write_reg(srv_pkg::REG_CHANNEL_MODE, mode);
        write_reg(srv_pkg::REG_IR_LENGTH, len);
        settings_used++;
        @(negedge clk);
    endtask

    initial begin
        int mode_pick;
        int len_pick;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme taps and samples, floor rounding, the ignored command, a clear.
        set_phase(srv_pkg::MODE_MONO, 4);
        queue_item(srv_pkg::CMD_LOAD, 0, 32767, -32768, $urandom, $urandom);
        queue_item(srv_pkg::CMD_LOAD, 1, -32768, 32767, $urandom, $urandom);
        queue_item(srv_pkg::CMD_LOAD, 2, -1, 1, $urandom, $urandom);
        queue_item(srv_pkg::CMD_LOAD, 3, 1, 0, $urandom, $urandom);
        queue_item(srv_pkg::CMD_LOAD, NTAPS - 1, -32768, -32768, $urandom, $urandom);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, 32767, -32768);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, -32768, 32767);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, -1, -1);
        queue_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, 1, 1);
        queue_item(srv_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, -32768, -32768);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, 32767, 32767);
        set_phase(srv_pkg::MODE_TRUE, 4);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, -32768, 32767);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, 32767, -32768);
        queue_item(srv_pkg::CMD_SAMPLE, 0, 0, 0, -1, 1);

        // Load the first taps full-scale negative, enough for every length used from here on,
        // so that a long run of full-scale samples saturates both outputs.
        set_phase(srv_pkg::MODE_QUASI, SAT_TAPS);
        for (int t = 0; t < SAT_TAPS; t++)
            queue_item(srv_pkg::CMD_LOAD, t, -32768, $urandom, $urandom, $urandom);
        queue_item(srv_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat (SAT_SAMPLES) queue_item(srv_pkg::CMD_SAMPLE, $urandom, $urandom, $urandom,
                                        -32768, 32767);

        // Short taps with the receiver held off, so the block backs up into its input.
        set_phase(srv_pkg::MODE_QUASI, 2);
        hold_off_req = 1'b1;
        fill_random(12);
        set_phase(MODE_SPARE, 0);
        fill_random(8);

        while (random_sent < RANDOM_ITEMS) begin
            mode_pick = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0: len_pick = 1;
                1: len_pick = $urandom_range(49, 160);
                default: len_pick = $urandom_range(2, 48);
            endcase
            set_phase(mode_pick[1:0], len_pick);
            fill_random($urandom_range(6, 12));
        end

        wait_idle();
        repeat (TAIL_CYC) @(negedge clk);

        $display("Run covered %0d transfers: %0d loads, %0d clears, %0d samples, %0d settings.",
                 items_taken, n_loads, n_clears, n_samples, settings_used);
        $display("Compared %0d output frames field by field; %0d mismatches found.",
                 frames_checked, errors);
        if (errors == 0 && expected_frames.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/srv_pkg.sv
rtl/core/srv_stream_if.sv
rtl/core/srv_ram.sv
rtl/core/srv_mac.sv
rtl/core/stereo_convolution_reverb.sv
tb/tb_stereo_convolution_reverb.sv
